@@ rtl/ble_prx_pkg.sv @@
// Shared types and constants for the BLE packet receiver.
// Used by ble_prx_cfg, ble_prx_corr, ble_prx_core and the top; depends on nothing.
`default_nettype none

package ble_prx_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    REG_BASE_ADDRESS    = 8'd0,
    REG_MATCH_THRESHOLD = 8'd1,
    REG_WHITENING_SEED  = 8'd2,
    REG_CRC_INIT        = 8'd3
  } reg_index_e;

  typedef struct packed {
    logic [31:0] base_address;
    logic [5:0]  match_threshold;
    logic [6:0]  whitening_seed;
    logic [23:0] crc_init;
  } cfg_t;

  localparam logic [31:0] BASE_ADDRESS_RST    = 32'h8E89_BED6;
  localparam logic [5:0]  MATCH_THRESHOLD_RST = 6'd0;
  localparam logic [6:0]  WHITENING_SEED_RST  = 7'd101;
  localparam logic [23:0] CRC_INIT_RST        = 24'h00_FFFF;

  localparam logic [6:0]  WHITEN_POLY   = 7'h11;
  localparam logic [31:0] CRC_POLY      = 32'h0000_065B;
  localparam logic [7:0]  PREAMBLE_ONE  = 8'hAA;
  localparam logic [7:0]  PREAMBLE_ZERO = 8'h55;
  localparam logic [7:0]  PREFIX_BYTE   = 8'h00;
  localparam int          CODE_CORE_BITS = 48;

endpackage

`default_nettype wire

@@ rtl/ble_prx_cfg.sv @@
// Configuration register file of the BLE packet receiver.
// Depends on ble_prx_pkg for register indexes and reset values.
`default_nettype none

module ble_prx_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  output ble_prx_pkg::cfg_t      cfg_o
);
  import ble_prx_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE_ADDRESS:    cfg_d.base_address    = cfg_data_i;
        REG_MATCH_THRESHOLD: cfg_d.match_threshold = cfg_data_i[5:0];
        REG_WHITENING_SEED:  cfg_d.whitening_seed  = cfg_data_i[6:0];
        REG_CRC_INIT:        cfg_d.crc_init        = cfg_data_i[23:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address    <= BASE_ADDRESS_RST;
      cfg_q.match_threshold <= MATCH_THRESHOLD_RST;
      cfg_q.whitening_seed  <= WHITENING_SEED_RST;
      cfg_q.crc_init        <= CRC_INIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/ble_prx_slicer.sv @@
// Input register: slices each soft sample to a hard bit and holds it for the core.
// Stand-alone; no package needed.
`default_nettype none

module ble_prx_slicer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] soft_sample_i,
  output logic                    bit_valid_o,
  output logic                    bit_o,
  input  wire logic               bit_take_i
);

  logic valid_q, valid_d;
  logic bit_q, bit_d;
  logic load;

  assign in_ready_o = !valid_q || bit_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    bit_d   = bit_q;
    if (load) begin
      valid_d = 1'b1;
      bit_d   = (soft_sample_i > 16'sd0);
    end else if (bit_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_valid_o = valid_q;
  assign bit_o       = bit_q;

endmodule

`default_nettype wire

@@ rtl/ble_prx_corr.sv @@
// Access code correlator: builds the code from the base address and tests the
// bit-error count of a window against the threshold. Depends on ble_prx_pkg.
`default_nettype none

module ble_prx_corr #(
  parameter int ACCESS_CODE_BITS = 48
) (
  input  wire logic [ACCESS_CODE_BITS-1:0] window_i,
  input  wire logic [31:0]                 base_address_i,
  input  wire logic [5:0]                  match_threshold_i,
  output logic                             match_o
);
  import ble_prx_pkg::*;

  localparam int CNT_W = $clog2(ACCESS_CODE_BITS + 1);

  logic [31:0]                 addr_rev;
  logic [CODE_CORE_BITS-1:0]   code_core;
  logic [63:0]                 code_wide;
  logic [ACCESS_CODE_BITS-1:0] diff;
  logic [CNT_W-1:0]            err_cnt;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      addr_rev[i] = base_address_i[31-i];
    end
  end

  assign code_core = {(base_address_i[0] ? PREAMBLE_ONE : PREAMBLE_ZERO), addr_rev, PREFIX_BYTE};
  assign code_wide = {{(64-CODE_CORE_BITS){1'b0}}, code_core};
  assign diff      = window_i ^ code_wide[ACCESS_CODE_BITS-1:0];

  always_comb begin
    err_cnt = '0;
    for (int i = 0; i < ACCESS_CODE_BITS; i++) begin
      err_cnt = err_cnt + CNT_W'(diff[i]);
    end
  end

  assign match_o = {{(8-CNT_W){1'b0}}, err_cnt} <= {2'b00, match_threshold_i};

endmodule

`default_nettype wire

@@ rtl/ble_prx_core.sv @@
// Deframer core: phase control, dewhitening, CRC, byte assembly and the result
// register. Depends on ble_prx_pkg and ble_prx_corr.
`default_nettype none

module ble_prx_core #(
  parameter int ACCESS_CODE_BITS  = 48,
  parameter int CRC_BITS          = 24,
  parameter int HEADER_BYTES      = 2,
  parameter int PACKET_COUNT_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  ble_prx_pkg::cfg_t                 cfg_i,
  input  wire logic                         bit_valid_i,
  input  wire logic                         bit_i,
  output logic                              bit_take_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [7:0]                        data_byte_o,
  output logic [7:0]                        frame_length_o,
  output logic                              crc_ok_o,
  output logic [PACKET_COUNT_BITS-1:0]      packet_id_o
);
  import ble_prx_pkg::*;

  localparam int WIN = (ACCESS_CODE_BITS > CRC_BITS) ? ACCESS_CODE_BITS : CRC_BITS;
  localparam int FW  = $clog2(WIN + 1);
  localparam logic [WIN-1:0] ACC_MASK = {WIN{1'b1}} >> (WIN - ACCESS_CODE_BITS);
  localparam logic [WIN-1:0] CRC_MASK = {WIN{1'b1}} >> (WIN - CRC_BITS);
  localparam logic [CRC_BITS-1:0] POLY = CRC_POLY[CRC_BITS-1:0];

  phase_e                      phase_q, phase_d;
  logic [WIN-1:0]              win_q, win_d;
  logic [FW-1:0]               fill_q, fill_d;
  logic [6:0]                  lfsr_q, lfsr_d;
  logic [CRC_BITS-1:0]         crc_q, crc_d;
  logic [7:0]                  shift_q, shift_d;
  logic [2:0]                  bitpos_q, bitpos_d;
  logic [7:0]                  bytepos_q, bytepos_d;
  logic [7:0]                  len_q, len_d;
  logic [PACKET_COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                        out_valid_q, out_valid_d;
  kind_e                       kind_q, kind_d;
  logic [7:0]                  data_q, data_d;
  logic [7:0]                  flen_q, flen_d;
  logic                        ok_q, ok_d;
  logic [PACKET_COUNT_BITS-1:0] pid_q, pid_d;

  // per-bit datapath
  logic                        wtop, dbit;
  logic [6:0]                  lfsr_step;
  logic [CRC_BITS-1:0]         crc_x, crc_step;
  logic [7:0]                  shift_step;
  logic                        byte_done;
  logic [7:0]                  bytepos_inc;
  logic [WIN-1:0]              win_search, win_crc;
  logic [FW-1:0]               fill_inc;
  logic                        search_full, crc_done, hdr_done, match;
  logic                        emit, fire;
  logic                        search_crc_d;

  assign wtop       = lfsr_q[6];
  assign lfsr_step  = {lfsr_q[5:0], 1'b0} ^ (wtop ? WHITEN_POLY : 7'd0);
  assign dbit       = bit_i ^ wtop;
  assign crc_x      = crc_q ^ {dbit, {(CRC_BITS-1){1'b0}}};
  assign crc_step   = crc_x[CRC_BITS-1] ? ({crc_x[CRC_BITS-2:0], 1'b0} ^ POLY)
                                        : {crc_x[CRC_BITS-2:0], 1'b0};
  assign shift_step  = {dbit, shift_q[7:1]};
  assign byte_done   = (bitpos_q == 3'd7);
  assign bytepos_inc = bytepos_q + 8'd1;
  assign win_search  = {win_q[WIN-2:0], bit_i} & ACC_MASK;
  assign win_crc     = {win_q[WIN-2:0], dbit} & CRC_MASK;
  assign fill_inc    = fill_q + FW'(1);
  assign search_full = (fill_q >= FW'(ACCESS_CODE_BITS - 1));
  assign crc_done    = (fill_inc >= FW'(CRC_BITS));
  assign hdr_done    = byte_done && (bytepos_inc >= 8'(HEADER_BYTES));

  ble_prx_corr #(
    .ACCESS_CODE_BITS(ACCESS_CODE_BITS)
  ) u_corr (
    .window_i          (win_search[ACCESS_CODE_BITS-1:0]),
    .base_address_i    (cfg_i.base_address),
    .match_threshold_i (cfg_i.match_threshold),
    .match_o           (match)
  );

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_SEARCH:  if (search_full && match) phase_d = PH_HEADER;
      PH_HEADER:  if (hdr_done) phase_d = (shift_step == 8'd0) ? PH_CRC : PH_PAYLOAD;
      PH_PAYLOAD: if (byte_done && (bytepos_inc >= len_q)) phase_d = PH_CRC;
      PH_CRC:     if (crc_done) phase_d = PH_SEARCH;
      default:    phase_d = PH_SEARCH;
    endcase
  end

  // result of this bit
  always_comb begin
    emit   = 1'b0;
    kind_d = KIND_HEADER;
    data_d = 8'd0;
    flen_d = len_q;
    ok_d   = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        emit   = hdr_done;
        flen_d = shift_step;
      end
      PH_PAYLOAD: begin
        emit   = byte_done;
        kind_d = KIND_PAYLOAD;
        data_d = shift_step;
      end
      PH_CRC: begin
        emit   = crc_done;
        kind_d = KIND_STATUS;
        ok_d   = (win_crc[CRC_BITS-1:0] == crc_q);
      end
      default: emit = 1'b0;
    endcase
  end

  assign pid_d      = cnt_q;
  assign fire       = bit_valid_i && (!emit || !out_valid_q || out_ready_i);
  assign bit_take_o = fire;

  // state datapath
  always_comb begin
    win_d     = win_q;
    fill_d    = fill_q;
    lfsr_d    = lfsr_q;
    crc_d     = crc_q;
    shift_d   = shift_q;
    bitpos_d  = bitpos_q;
    bytepos_d = bytepos_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    search_crc_d = 1'b0;
    case (phase_q)
      PH_SEARCH: begin
        win_d = win_search;
        if (!search_full) begin
          fill_d = fill_inc;
        end else if (match) begin
          lfsr_d    = cfg_i.whitening_seed;
          crc_d     = CRC_BITS'({8'd0, cfg_i.crc_init});
          len_d     = 8'd0;
          shift_d   = 8'd0;
          bitpos_d  = 3'd0;
          bytepos_d = 8'd0;
        end
      end
      PH_HEADER, PH_PAYLOAD: begin
        lfsr_d   = lfsr_step;
        crc_d    = crc_step;
        shift_d  = shift_step;
        bitpos_d = bitpos_q + 3'd1;
        if (byte_done) begin
          bytepos_d = bytepos_inc;
        end
        if (phase_q == PH_HEADER && hdr_done) begin
          len_d     = shift_step;
          shift_d   = 8'd0;
          bytepos_d = 8'd0;
          search_crc_d = (shift_step == 8'd0);
        end
        if (phase_q == PH_PAYLOAD && byte_done && (bytepos_inc >= len_q)) begin
          search_crc_d = 1'b1;
        end
        if (search_crc_d) begin
          win_d  = '0;
          fill_d = '0;
        end
      end
      PH_CRC: begin
        lfsr_d = lfsr_step;
        win_d  = win_crc;
        fill_d = fill_inc;
        if (crc_done) begin
          cnt_d  = cnt_q + PACKET_COUNT_BITS'(1);
          win_d  = '0;
          fill_d = '0;
        end
      end
      default: win_d = win_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEARCH;
      win_q       <= '0;
      fill_q      <= '0;
      lfsr_q      <= '0;
      crc_q       <= '0;
      shift_q     <= '0;
      bitpos_q    <= '0;
      bytepos_q   <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q   <= phase_d;
        win_q     <= win_d;
        fill_q    <= fill_d;
        lfsr_q    <= lfsr_d;
        crc_q     <= crc_d;
        shift_q   <= shift_d;
        bitpos_q  <= bitpos_d;
        bytepos_q <= bytepos_d;
        len_q     <= len_d;
        cnt_q     <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      flen_q <= flen_d;
      ok_q   <= ok_d;
      pid_q  <= pid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign frame_length_o = flen_q;
  assign crc_ok_o       = ok_q;
  assign packet_id_o    = pid_q;

  a_search_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SEARCH |-> fill_q <= FW'(ACCESS_CODE_BITS - 1))
    else $error("search window fill out of range");

  a_bit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SEARCH || phase_q == PH_CRC) |-> bitpos_q == 3'd0)
    else $error("bit position not byte aligned outside header/payload");

  a_payload_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> bytepos_q < len_q)
    else $error("payload byte position beyond length");

  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit && phase_q == PH_CRC) |=> phase_q == PH_SEARCH)
    else $error("status beat did not return to search");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit && phase_q == PH_CRC) |=>
      cnt_q == PACKET_COUNT_BITS'($past(cnt_q) + PACKET_COUNT_BITS'(1)))
    else $error("packet counter did not advance on status beat");

endmodule

`default_nettype wire

@@ rtl/ble_packet_receiver_unit.sv @@
// BLE packet receiver: access code search, dewhitening, CRC-24 check, byte output.
// Path: input register, core, result register; the two registers decouple the two sides.
// Throughput: one sample per cycle, unless a result beat waits on out_ready_i.
// Reset (async, active low): search phase, counters cleared, registers at defaults.
// Depends on ble_prx_pkg, ble_prx_cfg, ble_prx_slicer, ble_prx_core.
`default_nettype none

module ble_packet_receiver_unit #(
  parameter int ACCESS_CODE_BITS  = 48,
  parameter int CRC_BITS          = 24,
  parameter int HEADER_BYTES      = 2,
  parameter int PACKET_COUNT_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [7:0]                   cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [15:0]           soft_sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [7:0]                        data_byte_o,
  output logic [7:0]                        frame_length_o,
  output logic                              crc_ok_o,
  output logic [PACKET_COUNT_BITS-1:0]      packet_id_o
);
  import ble_prx_pkg::*;

  cfg_t cfg;
  logic bit_valid, bit_val, bit_take;

  ble_prx_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ble_prx_slicer u_slicer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .soft_sample_i (soft_sample_i),
    .bit_valid_o   (bit_valid),
    .bit_o         (bit_val),
    .bit_take_i    (bit_take)
  );

  ble_prx_core #(
    .ACCESS_CODE_BITS  (ACCESS_CODE_BITS),
    .CRC_BITS          (CRC_BITS),
    .HEADER_BYTES      (HEADER_BYTES),
    .PACKET_COUNT_BITS (PACKET_COUNT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .bit_valid_i    (bit_valid),
    .bit_i          (bit_val),
    .bit_take_o     (bit_take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .frame_length_o (frame_length_o),
    .crc_ok_o       (crc_ok_o),
    .packet_id_o    (packet_id_o)
  );

endmodule

`default_nettype wire
